// File: hw/rtl/tcc_pkg.sv
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_STOP       = 8;

  localparam int CELL_COUNT  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int SCROLL_LAST = CELL_COUNT - SCREEN_COLUMNS;
  localparam int CELL_AW     = $clog2(CELL_COUNT);
  localparam int SWEEP_W     = $clog2(CELL_COUNT + 1);
  localparam int COL_W       = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W       = $clog2(SCREEN_ROWS);
  localparam int CELL_W      = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // character codes
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [3:0]  bg_colour;
    logic [3:0]  fg_colour;
    logic [10:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [10:0] cursor_location;
    logic [15:0] cell_word;
  } result_t;

endpackage

// File: hw/rtl/tcc_ram.sv
`timescale 1ns / 1ps

module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// Put without scroll and unused request types answer in the next cycle; a read
// answers after the read state; put with scroll and clear answer after one
// framebuffer sweep through the single write port of the cell RAM.
// Throughput: one item at a time; a new item may start in the cycle its result shows.
// Reset: cursor homed, controller idle; framebuffer contents undefined until cleared.
// Results are one-cycle strobes; the receiver cannot stall.

module text_console_cursor_scroll (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tcc_pkg::cmd_t   cmd,
  output logic            done,
  output tcc_pkg::result_t result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  logic [1:0]                     state;
  logic [tcc_pkg::COL_W-1:0]      col;
  logic [tcc_pkg::ROW_W-1:0]      row;
  logic [tcc_pkg::SWEEP_W-1:0]    cnt;
  logic                           fill;
  logic                           rd_ok;
  logic [tcc_pkg::CELL_W-1:0]     word;

  logic                           accept;
  logic                           printable;
  logic                           idx_ok;
  logic [tcc_pkg::COL_W:0]        col_next;
  logic [tcc_pkg::ROW_W:0]        row_next;
  logic                           scroll;
  logic [tcc_pkg::CELL_AW-1:0]    pos;

  logic                           ram_we;
  logic [tcc_pkg::CELL_AW-1:0]    ram_waddr;
  logic [tcc_pkg::CELL_W-1:0]     ram_wdata;
  logic                           ram_re;
  logic [tcc_pkg::CELL_AW-1:0]    ram_raddr;
  logic [tcc_pkg::CELL_W-1:0]     ram_rdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign printable = (cmd.char_code >= tcc_pkg::CH_PRINT_LO) &&
                     (cmd.char_code <= tcc_pkg::CH_PRINT_HI);
  assign idx_ok    = int'(cmd.cell_index) < tcc_pkg::CELL_COUNT;
  assign pos       = tcc_pkg::CELL_AW'(int'(row) * tcc_pkg::SCREEN_COLUMNS + int'(col));

  // cursor motion for a put
  always_comb begin
    col_next = {1'b0, col};
    row_next = {1'b0, row};
    case (cmd.char_code)
      tcc_pkg::CH_BS: begin
        if (col != '0) col_next = col_next - 1'b1;
      end
      tcc_pkg::CH_TAB: begin
        col_next = (tcc_pkg::COL_W+1)'((int'(col) / tcc_pkg::TAB_STOP + 1) *
                                       tcc_pkg::TAB_STOP);
      end
      tcc_pkg::CH_CR: begin
        col_next = '0;
      end
      tcc_pkg::CH_LF: begin
        col_next = '0;
        row_next = row_next + 1'b1;
      end
      default: begin
        if (printable) col_next = col_next + 1'b1;
      end
    endcase
    if (int'(col_next) >= tcc_pkg::SCREEN_COLUMNS) begin
      col_next = '0;
      row_next = row_next + 1'b1;
    end
  end

  assign scroll = int'(row_next) >= tcc_pkg::SCREEN_ROWS;

  // RAM port control: character writes in idle, row copy or blank fill in a sweep.
  // The sweep reads one row ahead and writes one cell behind its count, so a read
  // never targets a cell already rewritten.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = {cmd.bg_colour, cmd.fg_colour, cmd.char_code};
    ram_re    = 1'b0;
    ram_raddr = tcc_pkg::CELL_AW'(cmd.cell_index);
    unique case (state)
      ST_IDLE: begin
        ram_we = accept && (cmd.req_type == tcc_pkg::REQ_PUT) && printable;
        ram_re = accept && (cmd.req_type == tcc_pkg::REQ_READ) && idx_ok;
      end
      ST_SWEEP: begin
        ram_re    = !fill && (int'(cnt) < tcc_pkg::SCROLL_LAST);
        ram_raddr = tcc_pkg::CELL_AW'(int'(cnt) + tcc_pkg::SCREEN_COLUMNS);
        ram_we    = (cnt != '0);
        ram_waddr = tcc_pkg::CELL_AW'(cnt - 1'b1);
        ram_wdata = (fill || int'(cnt) > tcc_pkg::SCROLL_LAST) ?
                    tcc_pkg::BLANK_CELL : ram_rdata;
      end
      default: begin
      end
    endcase
  end

  tcc_ram #(
    .WIDTH (tcc_pkg::CELL_W),
    .DEPTH (tcc_pkg::CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      col   <= '0;
      row   <= '0;
      cnt   <= '0;
      fill  <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            word <= '0;
            case (cmd.req_type)
              tcc_pkg::REQ_PUT: begin
                col <= col_next[tcc_pkg::COL_W-1:0];
                if (scroll) begin
                  row   <= tcc_pkg::ROW_W'(tcc_pkg::SCREEN_ROWS - 1);
                  fill  <= 1'b0;
                  cnt   <= '0;
                  state <= ST_SWEEP;
                end else begin
                  row  <= row_next[tcc_pkg::ROW_W-1:0];
                  done <= 1'b1;
                end
              end
              tcc_pkg::REQ_CLEAR: begin
                col   <= '0;
                row   <= '0;
                fill  <= 1'b1;
                cnt   <= '0;
                state <= ST_SWEEP;
              end
              tcc_pkg::REQ_READ: begin
                rd_ok <= idx_ok;
                state <= ST_READ;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_READ: begin
          word  <= rd_ok ? ram_rdata : '0;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_SWEEP: begin
          if (int'(cnt) == tcc_pkg::CELL_COUNT) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.cursor_location = 11'(int'(row) * tcc_pkg::SCREEN_COLUMNS + int'(col));
  assign result.cell_word       = word;

endmodule

// File: hw/rtl/tcc_checker.sv
`timescale 1ns / 1ps

module tcc_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input tcc_pkg::cmd_t    cmd,
  input logic             done,
  input tcc_pkg::result_t result
);

  logic accept;
  assign accept = start && !busy;

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("block not idle after reset");

  // every accepted item either keeps the block busy or answers next cycle
  a_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || done)
    else $error("accepted item neither in work nor answered");

  // an ignored code answers at once and leaves the cursor where it was
  a_ignored_code: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.req_type == tcc_pkg::REQ_PUT && cmd.char_code == 8'h00
    |=> done && result.cursor_location == $past(result.cursor_location)
        && result.cell_word == 16'h0000)
    else $error("ignored code moved the cursor");

  // out-of-range read returns zero once the block has passed through the read state
  a_read_oob: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.req_type == tcc_pkg::REQ_READ &&
    int'(cmd.cell_index) >= tcc_pkg::CELL_COUNT
    |-> ##2 done && result.cell_word == 16'h0000)
    else $error("out-of-range read not zero");

  // the cursor never points outside the screen on a result
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> int'(result.cursor_location) < tcc_pkg::CELL_COUNT)
    else $error("cursor outside the screen");

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);
